/* rtl/sfs_pkg.sv */
package sfs_pkg;

  // Operation carried by a request beat
  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // Status carried by a response beat
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_FREE_FULL = 2'd3
  } status_t;

  // Decision stage contents, waiting for the slot store read data
  typedef struct packed {
    status_t    status;
    logic [2:0] slot;
    logic       rd_word;
    logic       entry_valid;
  } stage_t;

endpackage

/* rtl/sfs_ram.sv */
module sfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/slot_store_free_stack.sv */
// Channel   Handshake             Fields                 Direction
// request   req_valid/req_stall   kind, value, index     into the block
// response  rsp_valid/rsp_stall   status, slot, word     out of the block
//
// One request beat may be taken every cycle; each gives one response beat.
// The decision stage reads the slot store RAM, whose registered read data
// then feeds the output register.
// Reset (rst, synchronous) empties the store and the free stack and marks
// every slot word as zero; no clearing pass is needed.
// rsp_stall holds both stages when full; req_stall rises only in that case.
module slot_store_free_stack #(
  parameter int SLOTS     = 8,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] value,
  input  logic [3:0]  index,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [2:0]  slot,
  output logic [31:0] word
);

  localparam int AW   = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0]   SLOTS_CNT = CW'(SLOTS);
  localparam logic [CMPW-1:0] SLOTS_CMP = CMPW'(SLOTS);

  // Counters and the cached top of the free stack
  logic [CW-1:0] used_count, used_count_next;
  logic [CW-1:0] free_count, free_count_next;
  logic [AW-1:0] top, top_next;

  // Zero-reads for slot words never written since reset
  logic [SLOTS-1:0] entry_valid;

  // Pipeline control
  logic          accept;
  logic          s1_valid, s1_adv;
  sfs_pkg::stage_t s1, s1_next;
  logic          s2_valid;

  sfs_pkg::kind_t   kind_sel;
  sfs_pkg::status_t status_c;
  logic [AW-1:0]    slot_c;
  logic             rd_word_c;

  logic [CMPW-1:0] idx_ext, used_ext;
  logic [AW-1:0]   idx_addr;

  // Slot store RAM
  logic                 sw_we;
  logic [WORD_BITS-1:0] sw_rdata;
  logic [WORD_BITS+31:0] value_wide;
  logic [WORD_BITS+31:0] rd_wide;

  // Free stack RAM; its read port always fetches the entry below the top
  logic          fs_we;
  logic [AW-1:0] fs_rdata;
  logic [CW-1:0] fs_rd_cnt;

  logic [AW+2:0] slot_wide;

  assign s1_adv    = s1_valid && (!s2_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_adv;
  assign accept    = req_valid && !req_stall;
  assign rsp_valid = s2_valid;

  assign kind_sel = sfs_pkg::kind_t'(kind);
  assign idx_ext  = CMPW'(index);
  assign used_ext = CMPW'(used_count);
  assign idx_addr = idx_ext[AW-1:0];

  // Keep only the low WORD_BITS of the pushed value
  assign value_wide = {{WORD_BITS{1'b0}}, value};

  // Decide the operation against the current counters
  always_comb begin
    status_c        = sfs_pkg::ST_OK;
    slot_c          = '0;
    rd_word_c       = 1'b0;
    used_count_next = used_count;
    free_count_next = free_count;
    top_next        = top;
    sw_we           = 1'b0;
    fs_we           = 1'b0;
    if (accept) begin
      unique case (kind_sel)
        sfs_pkg::KIND_PUSH: begin
          priority if (free_count != '0) begin
            // reuse the most recently freed slot
            slot_c          = top;
            free_count_next = free_count - CW'(1);
            top_next        = fs_rdata;
            sw_we           = 1'b1;
          end else if (used_count == SLOTS_CNT) begin
            status_c = sfs_pkg::ST_FULL;
          end else begin
            slot_c          = used_count[AW-1:0];
            used_count_next = used_count + CW'(1);
            sw_we           = 1'b1;
          end
        end
        sfs_pkg::KIND_POP: begin
          priority if (idx_ext >= used_ext) begin
            status_c = sfs_pkg::ST_BAD_INDEX;
          end else if (idx_ext == used_ext - CMPW'(1)) begin
            // highest slot: shrink the store
            used_count_next = used_count - CW'(1);
            rd_word_c       = 1'b1;
          end else if (free_count == SLOTS_CNT) begin
            status_c = sfs_pkg::ST_FREE_FULL;
          end else begin
            fs_we           = 1'b1;
            free_count_next = free_count + CW'(1);
            top_next        = idx_addr;
            rd_word_c       = 1'b1;
          end
        end
        sfs_pkg::KIND_PEEK: begin
          if (idx_ext >= SLOTS_CMP) begin
            status_c = sfs_pkg::ST_BAD_INDEX;
          end else begin
            rd_word_c = 1'b1;
          end
        end
        sfs_pkg::KIND_CLEAR: begin
          // drop both counters; stored words stay
          used_count_next = '0;
          free_count_next = '0;
        end
        default: begin
          status_c = sfs_pkg::ST_OK;
        end
      endcase
    end
  end

  // Fetch the entry that will sit below the top after this cycle
  assign fs_rd_cnt = free_count_next - CW'(2);

  assign slot_wide = {3'b000, slot_c};

  always_comb begin
    s1_next.status      = status_c;
    s1_next.slot        = slot_wide[2:0];
    s1_next.rd_word     = rd_word_c;
    s1_next.entry_valid = rd_word_c && entry_valid[idx_addr];
  end

  sfs_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (sw_we),
    .waddr(slot_c),
    .wdata(value_wide[WORD_BITS-1:0]),
    .re   (accept),
    .raddr(idx_addr),
    .rdata(sw_rdata)
  );

  sfs_ram #(
    .WIDTH(AW),
    .DEPTH(SLOTS)
  ) u_free_ram (
    .clk  (clk),
    .we   (fs_we),
    .waddr(free_count[AW-1:0]),
    .wdata(idx_addr),
    .re   (1'b1),
    .raddr(fs_rd_cnt[AW-1:0]),
    .rdata(fs_rdata)
  );

  // State and decision stage
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count  <= '0;
      free_count  <= '0;
      entry_valid <= '0;
      s1_valid    <= 1'b0;
    end else begin
      used_count <= used_count_next;
      free_count <= free_count_next;
      if (sw_we) begin
        entry_valid[slot_c] <= 1'b1;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // Output register: merge the RAM read data into the response beat
  assign rd_wide = {32'b0, sw_rdata};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (!rsp_stall) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      status <= s1.status;
      slot   <= s1.slot;
      word   <= (s1.rd_word && s1.entry_valid) ? rd_wide[31:0] : 32'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_used_bound : assert property (@(posedge clk) disable iff (rst)
    used_count <= SLOTS_CNT)
    else $error("used_count exceeds slot count");

  a_free_bound : assert property (@(posedge clk) disable iff (rst)
    free_count <= SLOTS_CNT)
    else $error("free_count exceeds slot count");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (s1_valid && s2_valid && rsp_stall))
    else $error("request stalled without a blocked response");

  a_reuse_pops : assert property (@(posedge clk) disable iff (rst)
    (accept && kind_sel == sfs_pkg::KIND_PUSH && free_count != '0)
    |=> free_count == $past(free_count) - CW'(1))
    else $error("push from free stack did not pop it");

  a_pop_shrinks : assert property (@(posedge clk) disable iff (rst)
    (accept && kind_sel == sfs_pkg::KIND_POP && idx_ext < used_ext &&
     idx_ext == used_ext - CMPW'(1))
    |=> used_count == $past(used_count) - CW'(1))
    else $error("pop of highest slot did not shrink the store");
`endif

endmodule

/* tb/slot_store_free_stack_test.sv */
`timescale 1ns / 1ps

module slot_store_free_stack_test;
  import sfs_pkg::*;

  localparam int SLOTS      = 8;
  localparam int RAND_BEATS = 512;

  // One reply beat as the block should produce it
  typedef struct {
    status_t     status;
    logic [2:0]  slot;
    logic [31:0] word;
  } reply_t;

  // One row of request stimulus; known marks a reply typed in by hand
  typedef struct {
    kind_t       kind;
    logic [31:0] value;
    logic [3:0]  index;
    int          reps;
    bit          known;
    reply_t      reply;
  } plan_row_t;

  // Traffic shape of the random part
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_ANY
  } mix_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  kind      = KIND_PEEK;
  logic [31:0] value     = '0;
  logic [3:0]  index     = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [1:0]  status;
  logic [2:0]  slot;
  logic [31:0] word;

  slot_store_free_stack dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .value     (value),
    .index     (index),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .slot      (slot),
    .word      (word)
  );

  // Mirror of the store state, advanced once per accepted request beat
  logic [31:0] mirror_words [SLOTS];
  logic [2:0]  mirror_free  [SLOTS];
  int          mirror_used;
  int          mirror_free_cnt;

  reply_t      awaited_replies [$];
  plan_row_t   directed_plan [$];

  int send_idle_pct  = 29;
  int recv_stall_pct = 50;
  int mismatches     = 0;
  int replies_seen   = 0;
  int beats_sent     = 0;
  int kind_hits   [4] = '{default: 0};
  int status_hits [4] = '{default: 0};

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs a handshake
  initial begin
    #2_000_000;
    $display("%0t: run did not finish, %0d replies still awaited", $realtime,
             awaited_replies.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Work out the reply to one request and advance the mirror state.
  function automatic reply_t predict_slot_op(kind_t k, logic [31:0] v, logic [3:0] ix);
    reply_t r;
    logic [2:0] s;
    r.status = ST_OK;
    r.slot   = '0;
    r.word   = '0;
    case (k)
      KIND_PUSH: begin
        if (mirror_free_cnt > 0) begin
          // reuse the most recently freed slot, even if it now lies above the used count
          s = mirror_free[mirror_free_cnt - 1];
          mirror_free_cnt--;
          mirror_words[s] = v;
          r.slot = s;
        end else if (mirror_used >= SLOTS) begin
          r.status = ST_FULL;
        end else begin
          mirror_words[mirror_used] = v;
          r.slot = mirror_used[2:0];
          mirror_used++;
        end
      end
      KIND_POP: begin
        if (int'(ix) >= mirror_used) begin
          r.status = ST_BAD_INDEX;
        end else if (int'(ix) == mirror_used - 1) begin
          // highest slot: shrink the store instead of stacking it
          mirror_used--;
          r.word = mirror_words[ix[2:0]];
        end else if (mirror_free_cnt >= SLOTS) begin
          r.status = ST_FREE_FULL;
        end else begin
          // a slot that is already free gets stacked once more
          mirror_free[mirror_free_cnt] = ix[2:0];
          mirror_free_cnt++;
          r.word = mirror_words[ix[2:0]];
        end
      end
      KIND_PEEK: begin
        if (int'(ix) >= SLOTS) r.status = ST_BAD_INDEX;
        else r.word = mirror_words[ix[2:0]];
      end
      default: begin
        // clear drops both counts; stored words stay
        mirror_used     = 0;
        mirror_free_cnt = 0;
      end
    endcase
    return r;
  endfunction

  task automatic plan(kind_t k, logic [31:0] v, logic [3:0] ix, int reps);
    plan_row_t row;
    row.kind  = k;
    row.value = v;
    row.index = ix;
    row.reps  = reps;
    row.known = 1'b0;
    row.reply = '{ST_OK, 3'd0, 32'd0};
    directed_plan.push_back(row);
  endtask

  task automatic plan_known(kind_t k, logic [31:0] v, logic [3:0] ix, status_t st,
                            logic [2:0] sl, logic [31:0] w);
    plan_row_t row;
    row.kind  = k;
    row.value = v;
    row.index = ix;
    row.reps  = 1;
    row.known = 1'b1;
    row.reply = '{st, sl, w};
    directed_plan.push_back(row);
  endtask

  // Offer one request beat, hold it until accepted, then record its reply.
  task automatic offer_beat(plan_row_t row);
    reply_t r;
    // drop valid for a random gap; never raise it in the step that lowered it
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= row.kind;
    value     <= row.value;
    index     <= row.index;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    r = predict_slot_op(row.kind, row.value, row.index);
    awaited_replies.push_back(row.known ? row.reply : r);
    kind_hits[row.kind]++;
    beats_sent++;
  endtask

  // Pick a random request, steered by the mirror so that the store fills,
  // drains and overflows its free stack often enough.
  function automatic plan_row_t random_row(mix_t mix);
    plan_row_t row;
    int roll;
    int push_w;
    int pop_w;
    int peek_w;
    push_w = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 10 : 35;
    pop_w  = (mix == MIX_FILL) ? 12 : (mix == MIX_DRAIN) ? 70 : 35;
    peek_w = (mix == MIX_ANY) ? 25 : 16;
    roll = $urandom_range(99);
    row.known = 1'b0;
    row.reps  = 1;
    row.reply = '{ST_OK, 3'd0, 32'd0};
    row.index = 4'($urandom_range(15));
    case ($urandom_range(9))
      0:       row.value = 32'h0000_0000;
      1:       row.value = 32'hFFFF_FFFF;
      default: row.value = $urandom;
    endcase
    if (roll < push_w) begin
      row.kind = KIND_PUSH;
    end else if (roll < push_w + pop_w) begin
      row.kind = KIND_POP;
      if (mirror_used > 0 && $urandom_range(99) < 85)
        row.index = 4'($urandom_range(mirror_used - 1));
    end else if (roll < push_w + pop_w + peek_w) begin
      row.kind = KIND_PEEK;
      if ($urandom_range(99) < 80) row.index = 4'($urandom_range(SLOTS - 1));
    end else begin
      row.kind = KIND_CLEAR;
    end
    return row;
  endfunction

  // Request side: directed table first, then random traffic in three idling phases
  initial begin
    mix_t mix;
    int   mix_left;
    for (int k = 0; k < SLOTS; k++) begin
      mirror_words[k] = '0;
      mirror_free[k]  = '0;
    end
    mirror_used     = 0;
    mirror_free_cnt = 0;

    // after reset, extremes and error codes
    plan_known(KIND_PEEK,  32'h0000_0000, 4'd0,  ST_OK,        3'd0, 32'h0);
    plan_known(KIND_PEEK,  32'hFFFF_FFFF, 4'd15, ST_BAD_INDEX, 3'd0, 32'h0);
    plan_known(KIND_POP,   32'h0000_0000, 4'd0,  ST_BAD_INDEX, 3'd0, 32'h0);
    plan_known(KIND_PUSH,  32'hFFFF_FFFF, 4'd0,  ST_OK,        3'd0, 32'h0);
    plan_known(KIND_PUSH,  32'h0000_0000, 4'd15, ST_OK,        3'd1, 32'h0);
    plan_known(KIND_PUSH,  32'hA5A5_A5A5, 4'd0,  ST_OK,        3'd2, 32'h0);
    plan_known(KIND_PUSH,  32'h5A5A_5A5A, 4'd0,  ST_OK,        3'd3, 32'h0);
    plan_known(KIND_PUSH,  32'h8000_0000, 4'd0,  ST_OK,        3'd4, 32'h0);
    plan_known(KIND_PUSH,  32'h0000_0001, 4'd0,  ST_OK,        3'd5, 32'h0);
    plan_known(KIND_PUSH,  32'h7F80_0000, 4'd0,  ST_OK,        3'd6, 32'h0);
    plan_known(KIND_PUSH,  32'h3F80_0000, 4'd0,  ST_OK,        3'd7, 32'h0);
    plan_known(KIND_PUSH,  32'h1234_5678, 4'd0,  ST_FULL,      3'd0, 32'h0);
    // highest slot shrinks, a lower slot is freed twice
    plan(KIND_POP,  32'h0, 4'd7, 1);
    plan(KIND_POP,  32'h0, 4'd2, 2);
    plan_known(KIND_POP,   32'h0000_0000, 4'd7,  ST_BAD_INDEX, 3'd0, 32'h0);
    plan(KIND_PUSH, 32'hDEAD_BEEF, 4'd0, 1);
    plan(KIND_POP,  32'h0, 4'd6, 1);
    // fill the free stack, then one more lower pop overflows it
    plan(KIND_POP,  32'h0, 4'd0, 7);
    plan_known(KIND_POP,   32'h0000_0000, 4'd1,  ST_FREE_FULL, 3'd0, 32'h0);
    plan(KIND_POP,  32'h0, 4'd5, 1);
    plan(KIND_PUSH, 32'h0000_FFFF, 4'd0, 1);
    plan_known(KIND_CLEAR, 32'hFFFF_FFFF, 4'd15, ST_OK,        3'd0, 32'h0);
    // leave a freed slot above the used count, then reuse it
    plan(KIND_PUSH, 32'hCAFE_F00D, 4'd0, 3);
    plan(KIND_POP,  32'h0, 4'd1, 1);
    plan(KIND_POP,  32'h0, 4'd2, 1);
    plan(KIND_POP,  32'h0, 4'd1, 1);
    plan(KIND_PUSH, 32'h0F0F_0F0F, 4'd0, 1);
    plan(KIND_PEEK, 32'h0, 4'd6, 1);
    plan(KIND_CLEAR, 32'h0, 4'd0, 1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[r]) begin
      repeat (directed_plan[r].reps) offer_beat(directed_plan[r]);
    end

    mix      = MIX_ANY;
    mix_left = 0;
    for (int n = 0; n < RAND_BEATS; n++) begin
      // receiver stalls more first, then the sender idles more, then neither
      if (n == RAND_BEATS / 3) begin
        send_idle_pct  = 50;
        recv_stall_pct = 29;
      end else if (n == 2 * RAND_BEATS / 3) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (mix_left == 0) begin
        mix      = mix_t'($urandom_range(2));
        mix_left = $urandom_range(10, 30);
      end
      mix_left--;
      offer_beat(random_row(mix));
    end
    req_valid <= 1'b0;

    // drain, then wait for the pipeline to show any stray beat
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d request beats (push %0d, pop %0d, peek %0d, clear %0d), %0d replies checked",
             beats_sent, kind_hits[KIND_PUSH], kind_hits[KIND_POP], kind_hits[KIND_PEEK],
             kind_hits[KIND_CLEAR], replies_seen);
    $display("replies by status: ok %0d, store full %0d, bad index %0d, free stack full %0d",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_BAD_INDEX],
             status_hits[ST_FREE_FULL]);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Reply side: check each accepted beat against the oldest awaited reply,
  // and pick the stall for the next cycle.
  always @(posedge clk) begin
    reply_t exp_r;
    if (!rst && rsp_valid && !rsp_stall) begin
      replies_seen++;
      if (awaited_replies.size() == 0) begin
        mismatches++;
        $display("%0t: reply beat with none awaited: status %0d slot %0d word %h",
                 $realtime, status, slot, word);
      end else begin
        exp_r = awaited_replies.pop_front();
        status_hits[exp_r.status]++;
        if (status !== exp_r.status) begin
          mismatches++;
          $display("%0t: status expected %0d actual %0d", $realtime, exp_r.status, status);
        end
        if (slot !== exp_r.slot) begin
          mismatches++;
          $display("%0t: slot expected %0d actual %0d", $realtime, exp_r.slot, slot);
        end
        if (word !== exp_r.word) begin
          mismatches++;
          $display("%0t: word expected %h actual %h", $realtime, exp_r.word, word);
        end
      end
    end
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

endmodule
